// ----- design/lcds_pkg.sv -----
// Shared types and constants of the lasso coordinate descent solver.
`timescale 1ns / 1ps
package lcds_pkg;

  localparam int AccW     = 64;
  localparam int FracBits = 16;
  localparam int DivW     = AccW + FracBits;

  localparam logic [31:0] LambdaReset    = 32'd0;
  localparam logic [31:0] ToleranceReset = 32'd66;
  localparam logic [15:0] SweepLimReset  = 16'd100;
  localparam logic [15:0] SampleDivReset = 16'd1;
  localparam logic [8:0]  RowsReset      = 9'd256;
  localparam logic [4:0]  ColsReset      = 5'd16;

  typedef enum logic [1:0] {
    OP_DESIGN   = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_SETUP    = 2'd2,
    OP_START    = 2'd3
  } lcds_op_e;

  typedef enum logic [2:0] {
    CFG_LAMBDA     = 3'd0,
    CFG_TOLERANCE  = 3'd1,
    CFG_SWEEP_LIM  = 3'd2,
    CFG_SAMPLE_DIV = 3'd3,
    CFG_ROWS       = 3'd4,
    CFG_COLS       = 3'd5
  } lcds_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_G_RDA, ST_G_RDB, ST_G_LDB, ST_MLO, ST_MHI, ST_MFIX, ST_G_ACC,
    ST_G_WR, ST_G_CP, ST_G_CPW, ST_C_B, ST_C_LD, ST_C_ACC, ST_C_X, ST_C_XL,
    ST_C_LAM, ST_C_SDIV, ST_C_SW, ST_C_DDIV, ST_C_DW, ST_C_DEC, ST_C_QS,
    ST_C_QW, ST_E_RD, ST_E_CMP, ST_E_END, ST_O_RD, ST_O_LD, ST_O_W
  } lcds_state_e;

  typedef struct packed {
    logic            start;
    logic            frac;
    logic [AccW-1:0] num;
    logic [AccW-1:0] den;
  } lcds_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quo;
  } lcds_div_rsp_t;

endpackage

// ----- design/lcds_if.sv -----
// Handshake channel interfaces of the solver: input items, results and configuration.
`timescale 1ns / 1ps
interface lcds_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [7:0]         row;
  logic [3:0]         col;
  logic signed [31:0] value;
  logic [31:0]        weight;
  modport source (output valid, op, row, col, value, weight, input ready);
  modport sink   (input valid, op, row, col, value, weight, output ready);
endinterface

interface lcds_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coef_index;
  logic signed [31:0] coefficient;
  logic [15:0]        sweeps_used;
  logic               converged;
  logic               last;
  modport source (output valid, coef_index, coefficient, sweeps_used, converged, last,
                  input ready);
  modport sink   (input valid, coef_index, coefficient, sweeps_used, converged, last,
                  output ready);
endinterface

interface lcds_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/lcds_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module lcds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/lcds_div.sv -----
// Bit-serial restoring divider for unsigned 64-bit operands, optional 16 fraction bits.
`timescale 1ns / 1ps
module lcds_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcds_pkg::lcds_div_req_t req_i,
  output lcds_pkg::lcds_div_rsp_t rsp_o
);
  import lcds_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] dvd_q;
  logic [AccW-1:0] rem_q;
  logic [AccW:0]   rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, dvd_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, req_i.den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The divisor is held steady by the caller for the whole division.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.frac ? {req_i.num, {FracBits{1'b0}}} : {{FracBits{1'b0}}, req_i.num};
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? AccW'(rem_sh - {1'b0, req_i.den}) : rem_sh[AccW-1:0];
      dvd_q <= {dvd_q[DivW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;

endmodule

// ----- design/lasso_coordinate_descent_solver_top.sv -----
// Top level of the weighted lasso solver by shooting coordinate descent.
// Load items are taken in the idle state; a start item runs Gram forming, sweeps and readout.
// Gram phase: nc*(nc+1)*nr products.
// Each sweep: two or three serial divisions per column.
// Readout: one coefficient at a time, each held until the sink takes it. No clearing pass after reset.
// Reset restores configuration defaults and the sweep count; the stores stay unwritten.
`timescale 1ns / 1ps
module lasso_coordinate_descent_solver_top #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcds_in_if.sink    in_i,
  lcds_cfg_if.sink   cfg_i,
  lcds_out_if.source out_o
);
  import lcds_pkg::*;

  // Index widths. Column and row counters carry one more bit so they can hold the count.
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNW     = CW + 1;
  localparam int RW      = $clog2(MAX_ROWS);
  localparam int RNW     = RW + 1;
  localparam int DDepth  = MAX_ROWS * MAX_COLS;
  localparam int DAW     = $clog2(DDepth);
  localparam int GDepth  = MAX_COLS * MAX_COLS;
  localparam int GAW     = (GDepth > 1) ? $clog2(GDepth) : 1;
  localparam int OutCols = (MAX_COLS < 16) ? MAX_COLS : 16;

  localparam logic signed [AccW-1:0] SMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [AccW:0]   SMax65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;

  // Configuration registers.
  logic [31:0] lambda_q, tol_q;
  logic [15:0] slimit_q, sdiv_q;
  logic [8:0]  rows_q;
  logic [4:0]  cols_q;

  // Sequencer state and datapath registers.
  lcds_state_e state_q, state_d, ret_q, ret_d;
  logic [CNW-1:0] a_q, a_d, b_q, b_d, nc_q, nc_d;
  logic [RNW-1:0] r_q, r_d, nr_q, nr_d;
  logic [15:0]    n_q, n_d, sweep_q, sweep_d;
  logic           conv_q, conv_d;
  logic signed [AccW-1:0] acc_q, acc_d, fix_q, fix_d, s_q, s_d, d_q, d_d, num_q, num_d;
  logic [31:0]    ma_q, ma_d, pen_q, pen_d, eps_q, eps_d;
  logic [63:0]    mb_q, mb_d, prod_lo_q, prod_lo_d, prod_hi_q, prod_hi_d;
  logic           neg_q, neg_d;
  logic [47:0]    lam_q, lam_d;

  // Result register.
  logic        ovalid_q, ovalid_d;
  logic [3:0]  oidx_q, oidx_d;
  logic [31:0] ocoef_q, ocoef_d;
  logic [15:0] osweep_q, osweep_d;
  logic        oconv_q, oconv_d, olast_q, olast_d;

  // Memory ports.
  logic            dsn_we;
  logic [DAW-1:0]  dsn_waddr, dsn_raddr;
  logic [31:0]     dsn_rdata;
  logic            rsp_we;
  logic [RW-1:0]   rsp_waddr, rsp_raddr;
  logic [31:0]     rsp_rdata;
  logic            gram_we;
  logic [GAW-1:0]  gram_waddr, gram_raddr;
  logic [63:0]     gram_wdata, gram_rdata;
  logic            crs_we;
  logic [CW-1:0]   crs_raddr;
  logic [63:0]     crs_rdata;
  logic            pen_we;
  logic [CW-1:0]   pen_waddr, pen_raddr;
  logic [31:0]     pen_rdata;
  logic            coef_we;
  logic [CW-1:0]   coef_waddr, coef_raddr;
  logic [31:0]     coef_wdata, coef_rdata;
  logic            prev_we;
  logic [CW-1:0]   prev_waddr, prev_raddr;
  logic [31:0]     prev_rdata;

  lcds_div_req_t div_req;
  lcds_div_rsp_t div_rsp;

  // Shared 32x32 multiplier.
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_x) * 64'(mul_y);

  // Combinational helpers.
  logic        in_acc, cfg_acc, out_acc;
  logic [CNW-1:0] nc_calc;
  logic [RNW-1:0] nr_calc;
  logic [31:0] y32;
  logic signed [AccW-1:0] lam64, qsigned;
  logic signed [32:0] diff, ndiff;
  logic [31:0] dlt;
  logic [31:0] qcoef;

  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign nc_calc = CNW'((32'(cols_q) > OutCols) ? OutCols : 32'(cols_q));
  assign nr_calc = RNW'((32'(rows_q) > MAX_ROWS) ? MAX_ROWS : 32'(rows_q));

  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] x,
                                                     input logic signed [AccW-1:0] y);
    logic signed [AccW:0] s;
    s = {x[AccW-1], x} + {y[AccW-1], y};
    if (s > SMax65) return SMax;
    else if (s < -SMax65) return -SMax;
    else return s[AccW-1:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? 64'(-x) : x;
  endfunction

  function automatic logic [DAW-1:0] dsn_addr(input logic [RNW-1:0] r,
                                              input logic [CNW-1:0] c);
    return DAW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  function automatic logic [GAW-1:0] gram_addr(input logic [CNW-1:0] x,
                                               input logic [CNW-1:0] y);
    return GAW'(32'(x) * MAX_COLS + 32'(y));
  endfunction

  // Product of the two magnitude halves, shifted right 16 and saturated.
  function automatic logic signed [AccW-1:0] fixmul(input logic [63:0] ph,
                                                    input logic [63:0] pl,
                                                    input logic neg);
    logic [63:0] r;
    logic        sat;
    sat = ph >= 64'h0000_8000_0000_0000;
    r   = {ph[47:0], 16'h0} + {16'h0, pl[63:16]};
    if (sat || r > 64'(SMax)) return neg ? -SMax : SMax;
    else return neg ? -$signed(r) : $signed(r);
  endfunction

  // Q16.16 quotient of the divider, saturated to 32 bits.
  assign qsigned = $signed(div_rsp.quo[AccW-1:0]);
  always_comb begin
    if (div_rsp.quo[DivW-1:31] != '0) begin
      qcoef = num_q[AccW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      qcoef = num_q[AccW-1] ? 32'(-div_rsp.quo[31:0]) : div_rsp.quo[31:0];
    end
  end

  assign lam64 = {16'h0, lam_q};
  assign diff  = 33'($signed(coef_rdata)) - 33'($signed(prev_rdata));
  assign ndiff = -diff;
  assign dlt   = diff[32] ? ndiff[31:0] : diff[31:0];

  // Next state and outputs of the sequencer.
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    a_d       = a_q;
    b_d       = b_q;
    r_d       = r_q;
    nc_d      = nc_q;
    nr_d      = nr_q;
    n_d       = n_q;
    sweep_d   = sweep_q;
    conv_d    = conv_q;
    acc_d     = acc_q;
    fix_d     = fix_q;
    s_d       = s_q;
    d_d       = d_q;
    num_d     = num_q;
    ma_d      = ma_q;
    mb_d      = mb_q;
    neg_d     = neg_q;
    pen_d     = pen_q;
    eps_d     = eps_q;
    lam_d     = lam_q;
    prod_lo_d = prod_lo_q;
    prod_hi_d = prod_hi_q;
    ovalid_d  = ovalid_q;
    oidx_d    = oidx_q;
    ocoef_d   = ocoef_q;
    osweep_d  = osweep_q;
    oconv_d   = oconv_q;
    olast_d   = olast_q;

    in_i.ready = 1'b0;
    mul_x      = ma_q;
    mul_y      = mb_q[31:0];
    y32        = dsn_rdata;

    dsn_we     = 1'b0;
    dsn_waddr  = dsn_addr(RNW'(in_i.row), CNW'(in_i.col));
    dsn_raddr  = dsn_addr(r_q, a_q);
    rsp_we     = 1'b0;
    rsp_waddr  = RW'(in_i.row);
    rsp_raddr  = r_q[RW-1:0];
    gram_we    = 1'b0;
    gram_waddr = gram_addr(a_q, b_q);
    gram_wdata = acc_q;
    gram_raddr = gram_addr(b_q, a_q);
    crs_we     = 1'b0;
    crs_raddr  = a_q[CW-1:0];
    pen_we     = 1'b0;
    pen_waddr  = CW'(in_i.col);
    pen_raddr  = a_q[CW-1:0];
    coef_we    = 1'b0;
    coef_waddr = a_q[CW-1:0];
    coef_wdata = '0;
    coef_raddr = a_q[CW-1:0];
    prev_we    = 1'b0;
    prev_waddr = a_q[CW-1:0];
    prev_raddr = a_q[CW-1:0];

    div_req.start = 1'b0;
    div_req.frac  = 1'b0;
    div_req.num   = mag64(acc_q);
    div_req.den   = {48'h0, n_q};

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          unique case (lcds_op_e'(in_i.op))
            OP_DESIGN: begin
              dsn_we = (32'(in_i.row) < MAX_ROWS) && (32'(in_i.col) < MAX_COLS);
            end
            OP_RESPONSE: begin
              rsp_we = 32'(in_i.row) < MAX_ROWS;
            end
            OP_SETUP: begin
              coef_we    = 32'(in_i.col) < MAX_COLS;
              pen_we     = 32'(in_i.col) < MAX_COLS;
              coef_waddr = CW'(in_i.col);
              coef_wdata = in_i.value;
            end
            OP_START: begin
              nc_d   = nc_calc;
              nr_d   = nr_calc;
              n_d    = (sdiv_q == '0) ? 16'd1 : sdiv_q;
              a_d    = '0;
              b_d    = '0;
              r_d    = '0;
              acc_d  = '0;
              conv_d = 1'b0;
              if (nc_calc != '0) begin
                state_d = (nr_calc == '0) ? ST_G_WR : ST_G_RDA;
              end
            end
            default: ;
          endcase
        end
      end
      ST_G_RDA: begin
        dsn_raddr = dsn_addr(r_q, a_q);
        state_d   = ST_G_RDB;
      end
      ST_G_RDB: begin
        // The last pass over a column pairs it with the response.
        dsn_raddr = dsn_addr(r_q, (b_q < nc_q) ? b_q : a_q);
        ma_d      = mag32(dsn_rdata);
        neg_d     = dsn_rdata[31];
        state_d   = ST_G_LDB;
      end
      ST_G_LDB: begin
        y32     = (b_q == nc_q) ? rsp_rdata : dsn_rdata;
        mb_d    = {32'h0, mag32(y32)};
        neg_d   = neg_q ^ y32[31];
        ret_d   = ST_G_ACC;
        state_d = ST_MLO;
      end
      ST_MLO: begin
        prod_lo_d = mul_p;
        state_d   = ST_MHI;
      end
      ST_MHI: begin
        mul_y     = mb_q[63:32];
        prod_hi_d = mul_p;
        state_d   = ST_MFIX;
      end
      ST_MFIX: begin
        fix_d   = fixmul(prod_hi_q, prod_lo_q, neg_q);
        state_d = ret_q;
      end
      ST_G_ACC: begin
        acc_d = sat_add(acc_q, fix_q);
        if (RNW'(r_q + 1'b1) < nr_q) begin
          r_d     = r_q + 1'b1;
          state_d = ST_G_RDA;
        end else begin
          state_d = ST_G_WR;
        end
      end
      ST_G_WR: begin
        acc_d = '0;
        r_d   = '0;
        if (b_q < nc_q) begin
          gram_we = 1'b1;
          b_d     = b_q + 1'b1;
          state_d = (nr_q == '0) ? ST_G_WR : ST_G_RDA;
        end else begin
          crs_we  = 1'b1;
          state_d = ST_G_CP;
        end
      end
      ST_G_CP: begin
        coef_raddr = a_q[CW-1:0];
        state_d    = ST_G_CPW;
      end
      ST_G_CPW: begin
        prev_we = 1'b1;
        b_d     = '0;
        if (CNW'(a_q + 1'b1) < nc_q) begin
          a_d     = a_q + 1'b1;
          state_d = (nr_q == '0) ? ST_G_WR : ST_G_RDA;
        end else begin
          sweep_d = '0;
          a_d     = '0;
          acc_d   = '0;
          state_d = (slimit_q == '0) ? ST_O_RD : ST_C_B;
        end
      end
      ST_C_B: begin
        coef_raddr = b_q[CW-1:0];
        gram_raddr = gram_addr(b_q, a_q);
        if (b_q == nc_q) begin
          state_d = ST_C_X;
        end else if (b_q == a_q) begin
          b_d = b_q + 1'b1;
        end else begin
          state_d = ST_C_LD;
        end
      end
      ST_C_LD: begin
        ma_d    = mag32(coef_rdata);
        mb_d    = mag64(gram_rdata);
        neg_d   = coef_rdata[31] ^ gram_rdata[63];
        ret_d   = ST_C_ACC;
        state_d = ST_MLO;
      end
      ST_C_ACC: begin
        acc_d   = sat_add(acc_q, fix_q);
        b_d     = b_q + 1'b1;
        state_d = ST_C_B;
      end
      ST_C_X: begin
        gram_raddr = gram_addr(a_q, a_q);
        state_d    = ST_C_XL;
      end
      ST_C_XL: begin
        acc_d   = sat_add(acc_q, -$signed(crs_rdata));
        d_d     = $signed(gram_rdata);
        pen_d   = pen_rdata;
        state_d = ST_C_LAM;
      end
      ST_C_LAM: begin
        mul_x     = lambda_q;
        mul_y     = pen_q;
        prod_lo_d = mul_p;
        state_d   = ST_C_SDIV;
      end
      ST_C_SDIV: begin
        lam_d         = prod_lo_q[63:16];
        div_req.start = 1'b1;
        state_d       = ST_C_SW;
      end
      ST_C_SW: begin
        if (div_rsp.done) begin
          s_d     = acc_q[AccW-1] ? -qsigned : qsigned;
          state_d = ST_C_DDIV;
        end
      end
      ST_C_DDIV: begin
        div_req.num   = mag64(d_q);
        div_req.start = 1'b1;
        state_d       = ST_C_DW;
      end
      ST_C_DW: begin
        div_req.num = mag64(d_q);
        if (div_rsp.done) begin
          d_d     = d_q[AccW-1] ? -qsigned : qsigned;
          state_d = ST_C_DEC;
        end
      end
      ST_C_DEC: begin
        if (d_q[AccW-1] || d_q == '0 || (s_q <= lam64 && s_q >= -lam64)) begin
          // Non-positive diagonal or gradient inside the threshold band.
          coef_we = 1'b1;
          acc_d   = '0;
          b_d     = '0;
          if (CNW'(a_q + 1'b1) < nc_q) begin
            a_d     = a_q + 1'b1;
            state_d = ST_C_B;
          end else begin
            a_d     = '0;
            eps_d   = '0;
            state_d = ST_E_RD;
          end
        end else begin
          num_d   = sat_add((s_q > lam64) ? lam64 : -lam64, -s_q);
          state_d = ST_C_QS;
        end
      end
      ST_C_QS: begin
        div_req.num   = mag64(num_q);
        div_req.den   = d_q;
        div_req.frac  = 1'b1;
        div_req.start = 1'b1;
        state_d       = ST_C_QW;
      end
      ST_C_QW: begin
        div_req.num  = mag64(num_q);
        div_req.den  = d_q;
        div_req.frac = 1'b1;
        if (div_rsp.done) begin
          coef_we    = 1'b1;
          coef_wdata = qcoef;
          acc_d      = '0;
          b_d        = '0;
          if (CNW'(a_q + 1'b1) < nc_q) begin
            a_d     = a_q + 1'b1;
            state_d = ST_C_B;
          end else begin
            a_d     = '0;
            eps_d   = '0;
            state_d = ST_E_RD;
          end
        end
      end
      ST_E_RD: begin
        state_d = ST_E_CMP;
      end
      ST_E_CMP: begin
        if (dlt > eps_q) begin
          eps_d = dlt;
        end
        prev_we    = 1'b1;
        coef_wdata = coef_rdata;
        if (CNW'(a_q + 1'b1) < nc_q) begin
          a_d     = a_q + 1'b1;
          state_d = ST_E_RD;
        end else begin
          state_d = ST_E_END;
        end
      end
      ST_E_END: begin
        sweep_d = sweep_q + 1'b1;
        a_d     = '0;
        b_d     = '0;
        acc_d   = '0;
        if (eps_q <= tol_q) begin
          conv_d  = 1'b1;
          state_d = ST_O_RD;
        end else if (({1'b0, sweep_q} + 17'd1) >= {1'b0, slimit_q}) begin
          state_d = ST_O_RD;
        end else begin
          state_d = ST_C_B;
        end
      end
      ST_O_RD: begin
        state_d = ST_O_LD;
      end
      ST_O_LD: begin
        ovalid_d = 1'b1;
        oidx_d   = 4'(a_q);
        ocoef_d  = coef_rdata;
        osweep_d = sweep_q;
        oconv_d  = conv_q;
        olast_d  = CNW'(a_q + 1'b1) == nc_q;
        state_d  = ST_O_W;
      end
      ST_O_W: begin
        if (out_acc) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            state_d = ST_IDLE;
          end else begin
            a_d     = a_q + 1'b1;
            state_d = ST_O_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Previous coefficients take the read-back coefficient, in the compare state via the write data.
  logic [31:0] prev_wdata;
  assign prev_wdata = (state_q == ST_E_CMP) ? coef_wdata : coef_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sweep_q  <= '0;
      ovalid_q <= 1'b0;
      lambda_q <= LambdaReset;
      tol_q    <= ToleranceReset;
      slimit_q <= SweepLimReset;
      sdiv_q   <= SampleDivReset;
      rows_q   <= RowsReset;
      cols_q   <= ColsReset;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      ovalid_q <= ovalid_d;
      if (cfg_acc) begin
        unique case (lcds_cfg_e'(cfg_i.index))
          CFG_LAMBDA:     lambda_q <= cfg_i.data;
          CFG_TOLERANCE:  tol_q    <= cfg_i.data;
          CFG_SWEEP_LIM:  slimit_q <= cfg_i.data[15:0];
          CFG_SAMPLE_DIV: sdiv_q   <= cfg_i.data[15:0];
          CFG_ROWS:       rows_q   <= cfg_i.data[8:0];
          CFG_COLS:       cols_q   <= cfg_i.data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q     <= ret_d;
    a_q       <= a_d;
    b_q       <= b_d;
    r_q       <= r_d;
    nc_q      <= nc_d;
    nr_q      <= nr_d;
    n_q       <= n_d;
    conv_q    <= conv_d;
    acc_q     <= acc_d;
    fix_q     <= fix_d;
    s_q       <= s_d;
    d_q       <= d_d;
    num_q     <= num_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    neg_q     <= neg_d;
    pen_q     <= pen_d;
    eps_q     <= eps_d;
    lam_q     <= lam_d;
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    oidx_q    <= oidx_d;
    ocoef_q   <= ocoef_d;
    osweep_q  <= osweep_d;
    oconv_q   <= oconv_d;
    olast_q   <= olast_d;
  end

  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = ovalid_q;
  assign out_o.coef_index  = oidx_q;
  assign out_o.coefficient = ocoef_q;
  assign out_o.sweeps_used = osweep_q;
  assign out_o.converged   = oconv_q;
  assign out_o.last        = olast_q;

  lcds_ram #(.WIDTH(32), .DEPTH(DDepth)) u_design (
    .clk_i, .we_i(dsn_we), .waddr_i(dsn_waddr), .wdata_i(in_i.value),
    .raddr_i(dsn_raddr), .rdata_o(dsn_rdata)
  );

  lcds_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_response (
    .clk_i, .we_i(rsp_we), .waddr_i(rsp_waddr), .wdata_i(in_i.value),
    .raddr_i(rsp_raddr), .rdata_o(rsp_rdata)
  );

  lcds_ram #(.WIDTH(64), .DEPTH(GDepth)) u_gram (
    .clk_i, .we_i(gram_we), .waddr_i(gram_waddr), .wdata_i(gram_wdata),
    .raddr_i(gram_raddr), .rdata_o(gram_rdata)
  );

  lcds_ram #(.WIDTH(64), .DEPTH(MAX_COLS)) u_cross (
    .clk_i, .we_i(crs_we), .waddr_i(a_q[CW-1:0]), .wdata_i(acc_q),
    .raddr_i(crs_raddr), .rdata_o(crs_rdata)
  );

  lcds_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_penalty (
    .clk_i, .we_i(pen_we), .waddr_i(pen_waddr), .wdata_i(in_i.weight),
    .raddr_i(pen_raddr), .rdata_o(pen_rdata)
  );

  lcds_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_coef (
    .clk_i, .we_i(coef_we && state_q != ST_E_CMP), .waddr_i(coef_waddr),
    .wdata_i(coef_wdata), .raddr_i(coef_raddr), .rdata_o(coef_rdata)
  );

  lcds_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .raddr_i(prev_raddr), .rdata_o(prev_rdata)
  );

  lcds_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // No new input transaction is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a result is pending");

  // The last result carries the highest column in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (32'(out_o.coef_index) + 1 == 32'(nc_q)))
    else $error("last flag on the wrong column");

  // Convergence needs at least one sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.converged) |-> (out_o.sweeps_used != '0))
    else $error("converged without a sweep");

endmodule
